/* rtl/wnaf_scalar_recoder_unit_macros.svh */
// assertion helpers for the wnaf recoder
`ifndef WNAF_SCALAR_RECODER_UNIT_MACROS_SVH
`define WNAF_SCALAR_RECODER_UNIT_MACROS_SVH

// property checked on every clock outside reset
`define WNAFREC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define WNAFREC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wnafrec_pkg.sv */
`timescale 1ns / 1ps

package wnafrec_pkg;

  localparam int ScalarBytesDef = 32;
  localparam int WindowBitsDef  = 5;

  localparam int ByteW      = 8;
  localparam int DigitPosW  = 9;
  localparam int DigitValW  = 5;
  localparam int DigitSpanW = 9;
  localparam int OutDataW   = 24;

  // scan window of bits held but not yet scanned
  localparam int PendW      = 16;
  localparam int MaxResults = 4;
  localparam int CntW       = $clog2(MaxResults + 1);

endpackage

/* rtl/wnaf_scalar_recoder_unit.sv */
`timescale 1ns / 1ps
// channel   | dir | tdata                                              | tuser | tlast
// s_axis    | in  | [7:0] scalar_byte                                  | -     | last_byte
// m_axis    | out | [8:0] digit_position, [13:9] digit_value,          | -     | is_end
//           |     | [22:14] digit_span, [23] zero                      |       |
// each byte is merged into the scan window, then the nonzero digits it releases come out one by one
// the rate is set by the single digit extractor, which finds one digit per cycle while the output is free
// the byte marked last also flushes the remaining digits and then emits the end record
// reset clears the scan state and the valid flags of the held input item and the output register
// a stalled output holds the digit extractor, and the next merge waits behind a ready digit

module wnaf_scalar_recoder_unit #(
  parameter int SCALAR_BYTES = wnafrec_pkg::ScalarBytesDef,
  parameter int WINDOW_BITS  = wnafrec_pkg::WindowBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [wnafrec_pkg::ByteW-1:0]    s_axis_tdata_i,   // scalar_byte
  input  logic                             s_axis_tlast_i,   // last_byte
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [wnafrec_pkg::OutDataW-1:0] m_axis_tdata_o,   // position, value, span, pad
  output logic                             m_axis_tlast_o    // is_end
);
  import wnafrec_pkg::*;

  localparam int ScalarBits = 8 * SCALAR_BYTES;
  localparam int PosW       = $clog2(ScalarBits + WINDOW_BITS + PendW + 8 + 1);
  localparam int KW         = $clog2(PendW);
  localparam int DigW       = WINDOW_BITS + 1;

  // input register
  logic                 inv_q, inv_d;
  logic [ByteW-1:0]     byte_q;
  logic                 last_q;

  // scan state
  logic [PendW-1:0]     pend_q, pend_d;
  logic                 carry_q, carry_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [PosW-1:0]      recv_q, recv_d;
  logic [PosW-1:0]      top_q, top_d;
  logic                 flush_q, flush_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  // result register
  logic                 mv_q, mv_d;
  logic [DigitPosW-1:0] mpos_q;
  logic [DigitValW-1:0] mval_q;
  logic                 mend_q;
  logic [DigitSpanW-1:0] mspan_q;

  logic [PendW-1:0]       diff;
  logic                   found;
  logic [KW-1:0]          k;
  logic [PosW-1:0]        dpos;
  logic                   in_lim;
  logic                   dig;
  logic [WINDOW_BITS-1:0] win;
  logic [WINDOW_BITS-1:0] word;
  logic                   new_carry;
  logic signed [DigW-1:0] digit;
  logic [PosW-1:0]        shift;
  logic [PosW-1:0]        wm1;
  logic [PosW-1:0]        skip;
  logic [PosW-1:0]        pos_m;
  logic [PendW-1:0]       pend_s;
  logic [PosW-1:0]        sh;
  logic                   has_room;
  logic [PendW-1:0]       pend_m;
  logic [PosW-1:0]        recv_m;
  logic [CntW-1:0]        cap;
  logic                   out_free;
  logic                   do_dig;
  logic                   do_end;
  logic                   do_merge;
  logic                   emit_dig;
  logic                   accept;

  // first position whose bit differs from the carry
  assign diff  = pend_q ^ {PendW{carry_q}};
  assign found = |diff;

  always_comb begin
    k = '0;
    for (int i = PendW - 1; i >= 0; i--) begin
      if (diff[i]) begin
        k = KW'(i);
      end
    end
  end

  assign dpos   = pos_q + PosW'(k);
  assign in_lim = flush_q ? (dpos <= PosW'(ScalarBits))
                          : (dpos + PosW'(WINDOW_BITS) <= recv_q);
  assign dig    = found && in_lim;

  // window value, mapped to a signed odd digit
  assign win       = WINDOW_BITS'(pend_q >> k);
  assign word      = win + WINDOW_BITS'(carry_q);
  assign new_carry = word[WINDOW_BITS-1];
  assign digit     = {new_carry, word};
  assign shift     = PosW'(k) + PosW'(WINDOW_BITS);

  // drop the leading run left by the previous byte, then append the new byte
  assign wm1      = PosW'(WINDOW_BITS - 1);
  assign skip     = (pos_q + wm1 < recv_q) ? (recv_q - wm1 - pos_q) : '0;
  assign pos_m    = pos_q + skip;
  assign pend_s   = pend_q >> skip;
  assign sh       = recv_q - pos_m;
  assign has_room = recv_q < PosW'(ScalarBits);
  assign pend_m   = has_room ? (pend_s | (PendW'(byte_q) << sh)) : pend_s;
  assign recv_m   = has_room ? (recv_q + PosW'(ByteW)) : recv_q;

  assign cap      = flush_q ? CntW'(MaxResults - 1) : CntW'(MaxResults);
  assign out_free = !mv_q || m_axis_tready_i;
  assign do_dig   = dig && out_free;
  assign do_end   = !dig && flush_q && out_free;
  assign do_merge = !dig && !flush_q && inv_q;
  assign emit_dig = do_dig && (cnt_q < cap);

  assign s_axis_tready_o = !inv_q || do_merge;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign inv_d           = accept || (inv_q && !do_merge);

  always_comb begin
    pend_d  = pend_q;
    carry_d = carry_q;
    pos_d   = pos_q;
    recv_d  = recv_q;
    top_d   = top_q;
    flush_d = flush_q;
    cnt_d   = cnt_q;
    if (do_dig) begin
      pend_d  = pend_q >> shift;
      pos_d   = pos_q + shift;
      carry_d = new_carry;
      top_d   = dpos + PosW'(1);
      if (cnt_q < CntW'(MaxResults)) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (do_end) begin
      pend_d  = '0;
      carry_d = 1'b0;
      pos_d   = '0;
      recv_d  = '0;
      top_d   = '0;
      flush_d = 1'b0;
      cnt_d   = '0;
    end else if (do_merge) begin
      pend_d  = pend_m;
      pos_d   = pos_m;
      recv_d  = recv_m;
      flush_d = last_q;
      cnt_d   = '0;
    end
  end

  always_comb begin
    mv_d = mv_q;
    if (emit_dig || do_end) begin
      mv_d = 1'b1;
    end else if (m_axis_tready_i) begin
      mv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= 1'b0;
      pend_q  <= '0;
      carry_q <= 1'b0;
      pos_q   <= '0;
      recv_q  <= '0;
      top_q   <= '0;
      flush_q <= 1'b0;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      inv_q   <= inv_d;
      pend_q  <= pend_d;
      carry_q <= carry_d;
      pos_q   <= pos_d;
      recv_q  <= recv_d;
      top_q   <= top_d;
      flush_q <= flush_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (emit_dig) begin
      mpos_q  <= DigitPosW'(dpos);
      mval_q  <= DigitValW'(digit);
      mend_q  <= 1'b0;
      mspan_q <= '0;
    end else if (do_end) begin
      mpos_q  <= '0;
      mval_q  <= '0;
      mend_q  <= 1'b1;
      mspan_q <= DigitSpanW'(top_q);
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tlast_o  = mend_q;
  assign m_axis_tdata_o  = {1'b0, mspan_q, mval_q, mpos_q};

`include "wnaf_scalar_recoder_unit_macros.svh"

  `WNAFREC_ASSERT(a_digit_odd,
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> m_axis_tdata_o[DigitPosW],
    "digit value is even")
  `WNAFREC_ASSERT(a_pend_bound,
    !flush_q |-> (pos_q <= recv_q && (recv_q - pos_q) < PosW'(PendW)),
    "unscanned bits exceed the scan window")
  `WNAFREC_ASSERT_NEXT(a_end_clears, do_end,
    (recv_q == '0 && pos_q == '0 && !carry_q && !flush_q),
    "scan state not cleared after end record")

endmodule
